@@ src/bbl_pkg.sv @@
`timescale 1ns / 1ps

package bbl_pkg;

    // Fixed number formats
    localparam int COEF_WIDTH    = 16;
    localparam int FRAC_BITS     = 14;
    localparam int NUM_CH        = 3;
    localparam int GUARD_WIDTH   = 3;
    localparam int CFG_IDX_WIDTH = 3;

    // Coefficient register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A2 = 3'd4;

    // Reset values, Q2.14 (b0 = 1.0, pass-through)
    localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 16'sd16384;
    localparam logic signed [COEF_WIDTH-1:0] COEF_ZERO = 16'sd0;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } coef_t;

    // Step strobes from the sequencer to every lane
    typedef struct packed {
        logic load;    // latch new sample
        logic fb;      // a1*w1, a2*w2
        logic wcalc;   // form w, overflow check, b1*w1, b2*w2
        logic ff;      // b0*w
        logic commit;  // result taken into output register, shift delays
    } lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_WCALC,
        ST_FF,
        ST_SUM
    } state_t;

endpackage

@@ src/butterworth_biquad_lowpass_unit.sv @@
`timescale 1ns / 1ps
// Steps from input accept to m_valid: feedback products, w, b0*w, sum.
// No request is taken while one is in flight; the next sample is taken in the
//   cycle its predecessor moves into the output register (m_ready permitting).
// Each lane owns two multipliers, reused across the FB, WCALC and FF steps.
// Reset (aresetn low, synchronous): coefficients to b0 = 1.0 and others 0,
//   delay lines cleared, sequencer idle, no result pending.

module butterworth_biquad_lowpass_unit
    import bbl_pkg::*;
#(
    parameter int LANES        = 3,
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
    input  logic [COEF_WIDTH-1:0]          cfg_data,
    // input samples
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_y,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_z,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered_x,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered_y,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered_z,
    output logic [GUARD_WIDTH-1:0]         m_guard_mask
);

    state_t    state_reg, state_next;
    lane_ctl_t ctl;
    coef_t     coef_reg;
    logic      out_free;
    logic      m_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0] samp     [NUM_CH];
    logic signed [SAMPLE_WIDTH-1:0] lane_y   [NUM_CH];
    logic [GUARD_WIDTH-1:0]         lane_g;

    logic signed [SAMPLE_WIDTH-1:0] fx_reg, fy_reg, fz_reg;
    logic [GUARD_WIDTH-1:0]         guard_reg;

    assign samp[0] = s_sample_x;
    assign samp[1] = s_sample_y;
    assign samp[2] = s_sample_z;

    // Coefficient registers; writes beyond a2 are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b1 <= COEF_ZERO;
            coef_reg.b2 <= COEF_ZERO;
            coef_reg.a1 <= COEF_ZERO;
            coef_reg.a2 <= COEF_ZERO;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_B0:  coef_reg.b0 <= cfg_data;
                REG_B1:  coef_reg.b1 <= cfg_data;
                REG_B2:  coef_reg.b2 <= cfg_data;
                REG_A1:  coef_reg.a1 <= cfg_data;
                REG_A2:  coef_reg.a2 <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_FB;
            ST_FB:    state_next = ST_WCALC;
            ST_WCALC: state_next = ST_FF;
            ST_FF:    state_next = ST_SUM;
            ST_SUM: begin
                if (out_free) begin
                    state_next = s_valid ? ST_FB : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_SUM) && out_free);
        ctl.load   = s_valid && s_ready;
        ctl.fb     = (state_reg == ST_FB);
        ctl.wcalc  = (state_reg == ST_WCALC);
        ctl.ff     = (state_reg == ST_FF);
        ctl.commit = (state_reg == ST_SUM) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Filter lanes; channels past LANES read as zero
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        if (c < LANES) begin : g_on
            bbl_lane #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .STATE_WIDTH  (STATE_WIDTH)
            ) u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .coef     (coef_reg),
                .sample   (samp[c]),
                .filtered (lane_y[c]),
                .guard    (lane_g[c])
            );
        end else begin : g_off
            assign lane_y[c] = '0;
            assign lane_g[c] = 1'b0;
        end
    end

    // Merge lanes into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            fx_reg    <= lane_y[0];
            fy_reg    <= lane_y[1];
            fz_reg    <= lane_y[2];
            guard_reg <= lane_g;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered_x = fx_reg;
    assign m_filtered_y = fy_reg;
    assign m_filtered_z = fz_reg;
    assign m_guard_mask = guard_reg;

endmodule

@@ src/bbl_lane.sv @@
`timescale 1ns / 1ps

module bbl_lane
    import bbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lane_ctl_t                      ctl,
    input  coef_t                          coef,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed [SAMPLE_WIDTH-1:0] filtered,
    output logic                           guard
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = STATE_WIDTH;
    localparam int PW = COEF_WIDTH + TW;        // product width
    localparam int FS = PW + 2;                 // sum of up to three products
    localparam int RW = FS - FRAC_BITS;         // after rounding shift
    localparam int WW = ((RW > SW) ? RW : SW) + 1;

    localparam logic signed [FS-1:0] RND     = FS'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WW-1:0] ST_MAX  = WW'((64'sd1 <<< (TW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] ST_MIN  = WW'(-(64'sd1 <<< (TW - 1)));
    localparam logic signed [WW-1:0] SMP_MAX = WW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] SMP_MIN = WW'(-(64'sd1 <<< (SW - 1)));

    logic signed [SW-1:0] x_reg;
    logic signed [TW-1:0] d1_reg, d2_reg;
    logic signed [TW-1:0] w_reg, w_next;
    logic                 guard_reg, guard_next;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;

    logic signed [COEF_WIDTH-1:0] m0_coef, m1_coef;
    logic signed [TW-1:0]         m0_op;
    logic signed [PW-1:0]         mul0, mul1;

    logic signed [FS-1:0] fb_sum, ff_sum;
    logic signed [RW-1:0] fb_rnd, ff_rnd;
    logic signed [WW-1:0] x_ext, w_full, x_sat, y_ext;

    // Operand selection for the two shared multipliers
    always_comb begin
        if (ctl.fb) begin
            m0_coef = coef.a1;
            m1_coef = coef.a2;
        end else begin
            m0_coef = coef.b1;
            m1_coef = coef.b2;
        end
        if (ctl.ff) begin
            m0_coef = coef.b0;
            m0_op   = w_reg;
        end else begin
            m0_op   = d1_reg;
        end
    end

    assign mul0 = m0_coef * m0_op;
    assign mul1 = m1_coef * d2_reg;

    // Feedback: w = x - round((a1*w1 + a2*w2) / 2^14)
    assign fb_sum = FS'(p0_reg) + FS'(p1_reg) + RND;
    assign fb_rnd = fb_sum[FS-1:FRAC_BITS];
    assign x_ext  = WW'(x_reg);
    assign w_full = x_ext - WW'(fb_rnd);

    // Overflow guard: substitute the (state-saturated) sample
    always_comb begin
        guard_next = (w_full > ST_MAX) || (w_full < ST_MIN);
        if (x_ext > ST_MAX) begin
            x_sat = ST_MAX;
        end else if (x_ext < ST_MIN) begin
            x_sat = ST_MIN;
        end else begin
            x_sat = x_ext;
        end
        w_next = guard_next ? TW'(x_sat) : TW'(w_full);
    end

    // Feedforward: y = sat(round((b0*w + b1*w1 + b2*w2) / 2^14))
    assign ff_sum = FS'(p0_reg) + FS'(p1_reg) + FS'(p2_reg) + RND;
    assign ff_rnd = ff_sum[FS-1:FRAC_BITS];
    assign y_ext  = WW'(ff_rnd);

    always_comb begin
        if (y_ext > SMP_MAX) begin
            filtered = SW'(SMP_MAX);
        end else if (y_ext < SMP_MIN) begin
            filtered = SW'(SMP_MIN);
        end else begin
            filtered = SW'(y_ext);
        end
    end

    assign guard = guard_reg;

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= sample;
        end
        if (ctl.fb || ctl.wcalc) begin
            p0_reg <= mul0;
            p1_reg <= mul1;
        end
        if (ctl.ff) begin
            p2_reg <= mul0;
        end
        if (ctl.wcalc) begin
            w_reg     <= w_next;
            guard_reg <= guard_next;
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (ctl.commit) begin
            d2_reg <= d1_reg;
            d1_reg <= w_reg;
        end
    end

endmodule

@@ src/bbl_checker.sv @@
`timescale 1ns / 1ps

module bbl_checker
    import bbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_filtered_x,
    input logic signed [SAMPLE_WIDTH-1:0] m_filtered_y,
    input logic signed [SAMPLE_WIDTH-1:0] m_filtered_z,
    input logic [GUARD_WIDTH-1:0]         m_guard_mask
);

    // No result is pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A request occupies the datapath through the FB, WCALC and FF states
    a_request_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("request taken before previous one finished");

    // Coefficient writes are never back-pressured
    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // A stalled result holds its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_filtered_x)
            && $stable(m_filtered_y) && $stable(m_filtered_z)
            && $stable(m_guard_mask))
        else $error("stalled result changed");

endmodule

bind butterworth_biquad_lowpass_unit bbl_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bbl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_filtered_x (m_filtered_x),
    .m_filtered_y (m_filtered_y),
    .m_filtered_z (m_filtered_z),
    .m_guard_mask (m_guard_mask)
);
